>>> rtl/gcddr_pkg.sv
// gcddr_pkg: micro-op codes, step addresses, control and status structs
// and the microcode table of the gcd sequencer
// no dependencies
package gcddr_pkg;

   localparam int UPC_W = 3;
   typedef logic [UPC_W-1:0] upc_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_INIT,
      OP_DOUBLE,
      OP_SUB,
      OP_SWAP,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      CND_ALWAYS,
      CND_START,
      CND_Y_ZERO,
      CND_X_LT_Y,
      CND_DBL_OK,
      CND_K_NZ
   } cond_type;

   localparam upc_type ST_WAIT   = UPC_W'(0);
   localparam upc_type ST_TEST   = UPC_W'(1);
   localparam upc_type ST_INIT   = UPC_W'(2);
   localparam upc_type ST_DOUBLE = UPC_W'(3);
   localparam upc_type ST_SUB    = UPC_W'(4);
   localparam upc_type ST_SWAP   = UPC_W'(5);
   localparam upc_type ST_EMIT   = UPC_W'(6);

   typedef struct packed {
      op_type   op;
      cond_type cond;
      logic     gate;
      upc_type  t_true;
      upc_type  t_false;
   } uword_type;

   typedef struct packed {
      op_type op;
      logic   en;
   } ctrl_type;

   typedef struct packed {
      logic y_zero;
      logic x_lt_y;
      logic dbl_ok;
      logic k_nz;
      logic out_free;
   } status_type;

   function automatic uword_type ucode_rom(input upc_type addr);
      uword_type w;
      unique case (addr)
         ST_WAIT:   w = '{OP_LOAD,   CND_START,  1'b1, ST_TEST,   ST_WAIT};
         ST_TEST:   w = '{OP_NONE,   CND_Y_ZERO, 1'b0, ST_EMIT,   ST_INIT};
         ST_INIT:   w = '{OP_INIT,   CND_X_LT_Y, 1'b0, ST_SWAP,   ST_DOUBLE};
         ST_DOUBLE: w = '{OP_DOUBLE, CND_DBL_OK, 1'b1, ST_DOUBLE, ST_SUB};
         ST_SUB:    w = '{OP_SUB,    CND_K_NZ,   1'b0, ST_SUB,    ST_SWAP};
         ST_SWAP:   w = '{OP_SWAP,   CND_ALWAYS, 1'b0, ST_TEST,   ST_TEST};
         ST_EMIT:   w = '{OP_EMIT,   CND_ALWAYS, 1'b0, ST_WAIT,   ST_WAIT};
         default:   w = '{OP_NONE,   CND_ALWAYS, 1'b0, ST_WAIT,   ST_WAIT};
      endcase
      return w;
   endfunction

endpackage

>>> rtl/integer_gcd_doubling_remainder_top.sv
// integer_gcd_doubling_remainder_top: greatest common divisor by Euclid's
// algorithm with remainders formed by doubling and subtracting back down
// depends on gcddr_pkg, gcddr_seq, gcddr_dp
//
//   channel  direction  tdata fields (lsb first)
//   req      in         first_value[31:0], second_value[63:32]
//   rsp      out        divisor[31:0]
//
// one transaction at a time, run by a seven-step microcode program
// steps per transaction: accept, then for each remainder step init, k doublings
// of the divisor (k below DATA_WIDTH) and subtraction back down, then swap, or
// swap at once for a dividend already below the divisor; last test, then emit
// reset clears the step counter and the result valid flag only
// a new request is taken while the last result is being taken; a stalled
// result holds the sequencer in its wait step
module integer_gcd_doubling_remainder_top #(
   parameter int DATA_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // first_value, second_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // divisor
);
   import gcddr_pkg::*;

   ctrl_type   ctrl;
   status_type status;
   upc_type    upc;

   gcddr_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .status     (status),
      .req_tready (req_tready),
      .ctrl       (ctrl),
      .upc        (upc)
   );

   gcddr_dp #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .first_value  (req_tdata[31:0]),
      .second_value (req_tdata[63:32]),
      .rsp_tready   (rsp_tready),
      .status       (status),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tdata    (rsp_tdata)
   );

`ifndef NO_ASSERTIONS
   a_accept_clears_out: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !rsp_tvalid)
      else $error("result pending after request transaction");

   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      (upc == ST_EMIT) |-> !rsp_tvalid)
      else $error("result overwritten while still pending");

   a_valid_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(upc == ST_EMIT))
      else $error("result raised outside emit step");
`endif

endmodule

>>> rtl/gcddr_seq.sv
// gcddr_seq: step counter, microcode fetch and branch condition select
// depends on gcddr_pkg
module gcddr_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  gcddr_pkg::status_type  status,
   output logic                   req_tready,
   output gcddr_pkg::ctrl_type    ctrl,
   output gcddr_pkg::upc_type     upc
);
   import gcddr_pkg::*;

   upc_type   upc_ff;
   upc_type   upc_in;
   uword_type uw;
   logic      start;
   logic      cond_met;

   assign uw         = ucode_rom(upc_ff);
   assign req_tready = (upc_ff == ST_WAIT) && status.out_free;
   assign start      = req_tvalid && req_tready;

   always_comb begin
      unique case (uw.cond)
         CND_ALWAYS: cond_met = 1'b1;
         CND_START:  cond_met = start;
         CND_Y_ZERO: cond_met = status.y_zero;
         CND_X_LT_Y: cond_met = status.x_lt_y;
         CND_DBL_OK: cond_met = status.dbl_ok;
         CND_K_NZ:   cond_met = status.k_nz;
         default:    cond_met = 1'b0;
      endcase
   end

   assign ctrl   = '{op: uw.op, en: (!uw.gate) || cond_met};
   assign upc_in = cond_met ? uw.t_true : uw.t_false;
   assign upc    = upc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= ST_WAIT;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

>>> rtl/gcddr_dp.sv
// gcddr_dp: operand, multiple, remainder and shift-count registers plus
// the result register, driven by the sequencer's control word
// depends on gcddr_pkg
module gcddr_dp #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  gcddr_pkg::ctrl_type    ctrl,
   input  logic [31:0]            first_value,
   input  logic [31:0]            second_value,
   input  logic                   rsp_tready,
   output gcddr_pkg::status_type  status,
   output logic                   rsp_tvalid,
   output logic [31:0]            rsp_tdata
);
   import gcddr_pkg::*;

   localparam int MW = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
   localparam int KW = $clog2(DATA_WIDTH);

   logic [DATA_WIDTH-1:0] x_ff, x_in, y_ff, y_in, d_ff, d_in, r_ff, r_in;
   logic [KW-1:0]         k_ff, k_in;
   logic [31:0]           out_ff, out_in;
   logic                  valid_ff, valid_in;
   logic [MW-1:0]         a_wide, b_wide, x_wide;
   logic [DATA_WIDTH-1:0] x_minus_d;

   assign a_wide    = MW'(first_value);
   assign b_wide    = MW'(second_value);
   assign x_wide    = MW'(x_ff);
   assign x_minus_d = x_ff - d_ff;

   assign status = '{
      y_zero:   (y_ff == '0),
      x_lt_y:   (x_ff < y_ff),
      dbl_ok:   (x_minus_d >= d_ff),
      k_nz:     (k_ff != '0),
      out_free: (!valid_ff) || rsp_tready
   };

   always_comb begin
      x_in     = x_ff;
      y_in     = y_ff;
      d_in     = d_ff;
      r_in     = r_ff;
      k_in     = k_ff;
      out_in   = out_ff;
      valid_in = valid_ff && !rsp_tready;
      if (ctrl.en) begin
         unique case (ctrl.op)
            OP_NONE: begin
            end
            OP_LOAD: begin
               x_in = a_wide[DATA_WIDTH-1:0];
               y_in = b_wide[DATA_WIDTH-1:0];
            end
            OP_INIT: begin
               d_in = y_ff;
               r_in = x_ff;
               k_in = '0;
            end
            OP_DOUBLE: begin
               d_in = {d_ff[DATA_WIDTH-2:0], 1'b0};
               k_in = k_ff + KW'(1);
            end
            OP_SUB: begin
               if (r_ff >= d_ff) begin
                  r_in = r_ff - d_ff;
               end
               d_in = {1'b0, d_ff[DATA_WIDTH-1:1]};
               k_in = k_ff - KW'(1);
            end
            OP_SWAP: begin
               x_in = y_ff;
               y_in = r_ff;
            end
            OP_EMIT: begin
               out_in   = x_wide[31:0];
               valid_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      d_ff   <= d_in;
      r_ff   <= r_in;
      k_ff   <= k_in;
      out_ff <= out_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = out_ff;

endmodule
